// ----- src/xwcc_pkg.sv -----
`default_nettype none
package xwcc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KeyWords = 4;
  localparam logic [WordW-1:0] Delta = 32'h9E3779B9;

  // host actions
  typedef enum logic [1:0] {
    ACT_ENCRYPT = 2'd0,
    ACT_TAG     = 2'd1,
    ACT_LOAD    = 2'd2,
    ACT_DECRYPT = 2'd3
  } action_e;

  // one queued transaction between front and back
  typedef struct packed {
    action_e          action;
    logic [WordW-1:0] word;
  } cmd_t;

  typedef logic [KeyWords-1:0][WordW-1:0] key_t;

  // XTEA mixing term: ((x << 4) ^ (x >> 5)) + x
  function automatic logic [WordW-1:0] mix(input logic [WordW-1:0] x);
    mix = ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage
`default_nettype wire

// ----- src/xtea_word_chain_cipher.sv -----
// Flow: encrypt/decrypt pass from push through the queue and a load into the back end,
// then one round pair per cycle until the result; tag and load pass queue and back end.
// No new item starts before the last is done, set by the shared round unit
// and by the single result register, which must be popped before the next item.
// Reset: asynchronous, active low; clears key words, chain word, queues and state.
`default_nettype none
module xtea_word_chain_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] data_word_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_word_o
);
  import xwcc_pkg::*;

  key_t key_q;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // write key words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  xwcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .data_word_i (data_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  xwcc_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ----- src/xwcc_front.sv -----
`default_nettype none
module xwcc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    action_i,
  input  wire logic [31:0]   data_word_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i,
  output xwcc_pkg::cmd_t     cmd_o
);
  import xwcc_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push_ok, pop_ok;

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push_ok     = push & ~full;
  assign pop_ok      = cmd_pop_i & cmd_valid_o;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_ok;
    rd_ptr_d = rd_ptr_q ^ pop_ok;
    count_d  = count_q;
    if (push_ok && !pop_ok) begin
      count_d = count_q + 2'd1;
    end else if (!push_ok && pop_ok) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the incoming transaction
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= '{action: action_e'(action_i), word: data_word_i};
    end
  end

endmodule
`default_nettype wire

// ----- src/xwcc_back.sv -----
`default_nettype none
module xwcc_back #(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire xwcc_pkg::key_t key_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  input  wire xwcc_pkg::cmd_t cmd_i,
  output logic                empty,
  input  wire logic           pop,
  output logic [31:0]         out_word_o
);
  import xwcc_pkg::*;

  localparam int unsigned CntW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [63:0] SumFull = 64'(Delta) * 64'(ROUNDS);
  localparam logic [WordW-1:0] DecSum = SumFull[WordW-1:0];
  localparam logic [CntW-1:0] LastCnt = CntW'(ROUNDS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             dec_q, dec_d;
  logic [WordW-1:0] a_q, a_d, b_q, b_d, s_q, s_d;
  logic [WordW-1:0] chain_q, chain_d;
  logic [WordW-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] enc_a, enc_s, enc_b;
  logic [WordW-1:0] dec_b, dec_s, dec_a;

  // one round pair in each direction
  always_comb begin
    enc_a = a_q + (mix(b_q) ^ (s_q + key_i[s_q[1:0]]));
    enc_s = s_q + Delta;
    enc_b = b_q + (mix(enc_a) ^ (enc_s + key_i[enc_s[12:11]]));
    dec_b = b_q - (mix(a_q) ^ (s_q + key_i[s_q[12:11]]));
    dec_s = s_q - Delta;
    dec_a = a_q - (mix(dec_b) ^ (dec_s + key_i[dec_s[1:0]]));
  end

  assign empty      = ~out_valid_q;
  assign out_word_o = out_q;

  // sequence: take a transaction, iterate rounds for encrypt/decrypt, hold result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dec_d       = dec_q;
    a_d         = a_q;
    b_d         = b_q;
    s_d         = s_q;
    chain_d     = chain_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~pop;
    cmd_pop_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.action) inside
            ACT_ENCRYPT, ACT_DECRYPT: begin
              dec_d   = (cmd_i.action == ACT_DECRYPT);
              a_d     = cmd_i.word;
              b_d     = chain_q;
              s_d     = (cmd_i.action == ACT_DECRYPT) ? DecSum : '0;
              cnt_d   = LastCnt;
              state_d = S_RUN;
            end
            ACT_TAG: begin
              out_d       = chain_q;
              out_valid_d = 1'b1;
            end
            ACT_LOAD: begin
              chain_d = cmd_i.word;
            end
            default: begin
              chain_d = chain_q;
            end
          endcase
        end
      end
      S_RUN: begin
        a_d   = dec_q ? dec_a : enc_a;
        b_d   = dec_q ? dec_b : enc_b;
        s_d   = dec_q ? dec_s : enc_s;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          out_d       = dec_q ? dec_a : enc_a;
          chain_d     = dec_q ? dec_b : enc_b;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  // hold datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dec_q <= dec_d;
    a_q   <= a_d;
    b_q   <= b_d;
    s_q   <= s_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire
